>>> sv/twm_pkg.sv
`default_nettype none

package twm_pkg;

    // word kinds on the input channel
    localparam logic [2:0] OP_TIME     = 3'd0;
    localparam logic [2:0] OP_FEEDBACK = 3'd1;
    localparam logic [2:0] OP_HLT      = 3'd2;
    localparam logic [2:0] OP_LLT      = 3'd3;
    localparam logic [2:0] OP_STATUS   = 3'd4;
    localparam logic [2:0] OP_OTHER    = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_FRAME       = 3'd0;
    localparam logic [2:0] KIND_TIMEOUT     = 3'd1;
    localparam logic [2:0] KIND_NO_MATCH    = 3'd2;
    localparam logic [2:0] KIND_REPEAT_DIFF = 3'd3;
    localparam logic [2:0] KIND_REPEAT_SAME = 3'd4;
    localparam logic [2:0] KIND_OVERFLOW    = 3'd5;

    localparam logic [9:0]  TIMEOUT_RESET = 10'd100;
    localparam logic [63:0] FAKE_HLT_A    = 64'h1;
    localparam logic [63:0] FAKE_HLT_B    = 64'h1 << 16;

    typedef enum logic [1:0] {
        EM_EXEC,
        EM_TIMEOUT,
        EM_MATCH,
        EM_NOMATCH
    } emit_sel_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        from_hlt;
        logic [63:0] frame_time;
        logic [63:0] frame_payload;
        logic [31:0] frame_trigger;
        logic [31:0] frame_sequence;
        logic        error_seen;
        logic        last;
    } result_t;

    typedef struct packed {
        logic      capture;
        logic      exec;
        logic      side_hlt;
        logic      load_want;
        logic      pop_trig;
        logic      pop_pay;
        logic      emit;
        emit_sel_t sel;
        logic      flush;
    } cmd_t;

    typedef struct packed {
        logic exec_emit;
        logic exec_repeat;
        logic trig_empty;
        logic pay_empty;
        logic timed_out;
        logic pay_less;
        logic pay_equal;
        logic can_emit;
        logic pend_valid;
    } status_t;

endpackage

`default_nettype wire

>>> sv/twm_in_if.sv
`default_nettype none

interface twm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] time_req;
    logic [63:0] trigger_bits;
    logic [15:0] beam_status;
    logic [31:0] crt_status;
    logic [15:0] pds_status;

    modport source (output valid, op, time_req, trigger_bits, beam_status, crt_status,
                    pds_status, input ready);
    modport sink (input valid, op, time_req, trigger_bits, beam_status, crt_status,
                  pds_status, output ready);
endinterface

`default_nettype wire

>>> sv/twm_out_if.sv
`default_nettype none

interface twm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        from_hlt;
    logic [63:0] frame_time;
    logic [63:0] frame_payload;
    logic [31:0] frame_trigger;
    logic [31:0] frame_sequence;
    logic        error_seen;
    logic        last;

    modport source (output valid, kind, from_hlt, frame_time, frame_payload, frame_trigger,
                    frame_sequence, error_seen, last, input ready);
    modport sink (input valid, kind, from_hlt, frame_time, frame_payload, frame_trigger,
                  frame_sequence, error_seen, last, output ready);
endinterface

`default_nettype wire

>>> sv/trigger_word_timestamp_matcher.sv
`default_nettype none

// Trigger word timestamp matcher. Decoded trigger-board words enter on the words
// channel one item at a time; each item yields zero or more result items on the
// results channel, the final one of an item marked by last. Time words load the
// reference time, feedback words set the sticky error flag, and HLT, LLT and
// channel-status words are checked for repeats and queued. After each word that is
// not a repeat the block resolves HLTs against LLT payloads and then LLTs against
// status payloads, one queue head at a time, through block RAMs with a registered
// read. An item is first captured and then executed; a repeated word then goes
// straight to the final hand-off. Otherwise each side finds its trigger queue empty,
// or reads its head and tests it for a timeout or an empty payload queue; a timeout
// drops the head, and each payload compared against the head (a match, a no-match
// or a stale payload skipped) is read and then evaluated. Finally the held final
// result is handed off. A word that frees many queued triggers or skips many
// payloads takes longer. The block stalls while the results side holds both its
// output register and the held-back result. The match timeout register (timeout_reg)
// is written by cfg_we/cfg_wdata; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module trigger_word_timestamp_matcher #(
    parameter int TRIGGER_QUEUE_DEPTH = 16,
    parameter int PAYLOAD_QUEUE_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [9:0] cfg_wdata,
    twm_in_if.sink          words,
    twm_out_if.source       results
);
    import twm_pkg::*;

    cmd_t    cmd;
    status_t st;
    result_t res;
    logic    res_valid;
    logic    in_ready;

    // sequencer: walks enqueue, hlt side, llt side, then final hand-off
    twm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (words.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // queues, previous-word state, comparators and output registers
    twm_dpath #(
        .TRIGGER_QUEUE_DEPTH (TRIGGER_QUEUE_DEPTH),
        .PAYLOAD_QUEUE_DEPTH (PAYLOAD_QUEUE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .op           (words.op),
        .time_req     (words.time_req),
        .trigger_bits (words.trigger_bits),
        .beam_status  (words.beam_status),
        .crt_status   (words.crt_status),
        .pds_status   (words.pds_status),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (res_valid),
        .out_ready    (results.ready),
        .out_res      (res)
    );

    assign words.ready            = in_ready;
    assign results.valid          = res_valid;
    assign results.kind           = res.kind;
    assign results.from_hlt       = res.from_hlt;
    assign results.frame_time     = res.frame_time;
    assign results.frame_payload  = res.frame_payload;
    assign results.frame_trigger  = res.frame_trigger;
    assign results.frame_sequence = res.frame_sequence;
    assign results.error_seen     = res.error_seen;
    assign results.last           = res.last;

endmodule

`default_nettype wire

>>> sv/twm_ram.sv
`default_nettype none

module twm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/twm_ctrl.sv
`default_nettype none

module twm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire twm_pkg::status_t st,
    output twm_pkg::cmd_t         cmd
);
    import twm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_T_WAIT,
        S_T_EVAL,
        S_P_WAIT,
        S_P_EVAL,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            side_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        side_next     = side_reg;
        cmd           = '0;
        cmd.sel       = EM_EXEC;
        cmd.side_hlt  = side_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!st.exec_emit || st.can_emit)
                begin
                    cmd.exec  = 1'b1;
                    cmd.emit  = st.exec_emit;
                    side_next = 1'b1;
                    state_next = st.exec_repeat ? S_FLUSH : S_T_WAIT;
                end
            end
            S_T_WAIT:
            begin
                if (st.trig_empty)
                begin
                    side_next  = 1'b0;
                    state_next = side_reg ? S_T_WAIT : S_FLUSH;
                end
                else
                begin
                    state_next = S_T_EVAL;
                end
            end
            S_T_EVAL:
            begin
                priority if (st.timed_out)
                begin
                    if (st.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.sel      = EM_TIMEOUT;
                        cmd.pop_trig = 1'b1;
                        state_next   = S_T_WAIT;
                    end
                end
                else if (st.pay_empty)
                begin
                    side_next  = 1'b0;
                    state_next = side_reg ? S_T_WAIT : S_FLUSH;
                end
                else
                begin
                    cmd.load_want = 1'b1;
                    state_next    = S_P_WAIT;
                end
            end
            S_P_WAIT:
            begin
                state_next = S_P_EVAL;
            end
            S_P_EVAL:
            begin
                priority if (st.pay_less)
                begin
                    cmd.pop_pay = 1'b1;
                    state_next  = S_T_WAIT;
                end
                else
                begin
                    if (st.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.sel      = st.pay_equal ? EM_MATCH : EM_NOMATCH;
                        cmd.pop_trig = 1'b1;
                        cmd.pop_pay  = st.pay_equal;
                        state_next   = S_T_WAIT;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (st.can_emit)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/twm_dpath.sv
`default_nettype none

module twm_dpath #(
    parameter int TRIGGER_QUEUE_DEPTH = 16,
    parameter int PAYLOAD_QUEUE_DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [9:0]       cfg_wdata,
    input  wire logic [2:0]       op,
    input  wire logic [63:0]      time_req,
    input  wire logic [63:0]      trigger_bits,
    input  wire logic [15:0]      beam_status,
    input  wire logic [31:0]      crt_status,
    input  wire logic [15:0]      pds_status,
    input  wire twm_pkg::cmd_t    cmd,
    output twm_pkg::status_t      st,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output twm_pkg::result_t      out_res
);
    import twm_pkg::*;

    localparam int TAW = $clog2(TRIGGER_QUEUE_DEPTH);
    localparam int TCW = $clog2(TRIGGER_QUEUE_DEPTH + 1);
    localparam int PAW = $clog2(PAYLOAD_QUEUE_DEPTH);
    localparam int PCW = $clog2(PAYLOAD_QUEUE_DEPTH + 1);
    localparam logic [TCW-1:0] T_FULL = TCW'(TRIGGER_QUEUE_DEPTH);
    localparam logic [PCW-1:0] P_FULL = PCW'(PAYLOAD_QUEUE_DEPTH);

    function automatic logic [TAW-1:0] t_tail(input logic [TAW-1:0] h, input logic [TCW-1:0] c);
        logic [TCW:0] s;
        s = (TCW+1)'(h) + {1'b0, c};
        if (s >= (TCW+1)'(TRIGGER_QUEUE_DEPTH))
        begin
            s = s - (TCW+1)'(TRIGGER_QUEUE_DEPTH);
        end
        return s[TAW-1:0];
    endfunction

    function automatic logic [PAW-1:0] p_tail(input logic [PAW-1:0] h, input logic [PCW-1:0] c);
        logic [PCW:0] s;
        s = (PCW+1)'(h) + {1'b0, c};
        if (s >= (PCW+1)'(PAYLOAD_QUEUE_DEPTH))
        begin
            s = s - (PCW+1)'(PAYLOAD_QUEUE_DEPTH);
        end
        return s[PAW-1:0];
    endfunction

    function automatic logic [TAW-1:0] t_inc(input logic [TAW-1:0] h);
        return (h == TAW'(TRIGGER_QUEUE_DEPTH - 1)) ? '0 : h + TAW'(1);
    endfunction

    function automatic logic [PAW-1:0] p_inc(input logic [PAW-1:0] h);
        return (h == PAW'(PAYLOAD_QUEUE_DEPTH - 1)) ? '0 : h + PAW'(1);
    endfunction

    // captured word
    logic [2:0]  op_reg;
    logic [63:0] t_reg, tb_reg;
    logic [15:0] beam_reg, pds_reg;
    logic [31:0] crt_reg;

    logic [9:0]  timeout_reg;
    logic [63:0] ref_time_reg;
    logic        err_reg;
    logic [63:0] prev_hlt_time_reg, prev_llt_time_reg, prev_st_time_reg;
    logic [60:0] prev_hlt_bits_reg;
    logic [31:0] prev_llt_bits_reg;
    logic [63:0] prev_st_bits_reg;
    logic [31:0] hlt_seq_reg, llt_seq_reg;
    logic [63:0] want_reg;

    logic [TAW-1:0] hq_head_reg, lq_head_reg;
    logic [TCW-1:0] hq_cnt_reg, lq_cnt_reg;
    logic [PAW-1:0] lpq_head_reg, sq_head_reg;
    logic [PCW-1:0] lpq_cnt_reg, sq_cnt_reg;

    result_t pend_reg, out_reg;
    logic    pend_valid_reg, out_valid_reg;

    // word decode
    logic        is_hlt, is_llt, is_st, rep, ovf;
    logic [63:0] st_time, st_pay;
    logic        hq_we, lq_we, sq_we;
    logic [PAW-1:0] lpq_waddr, sq_waddr;

    assign is_hlt  = (op_reg == OP_HLT);
    assign is_llt  = (op_reg == OP_LLT);
    assign is_st   = (op_reg == OP_STATUS);
    assign st_time = {ref_time_reg[63:60], t_reg[59:0]};
    assign st_pay  = {pds_reg, crt_reg, beam_reg};
    assign rep = (is_hlt && (t_reg == prev_hlt_time_reg))
              || (is_llt && (t_reg == prev_llt_time_reg))
              || (is_st && (st_time == prev_st_time_reg));
    assign ovf = !rep && ((is_hlt && (hq_cnt_reg == T_FULL))
                       || (is_llt && (lq_cnt_reg == T_FULL)));

    assign hq_we = cmd.exec && is_hlt && !rep && !ovf;
    assign lq_we = cmd.exec && is_llt && !rep && !ovf;
    assign sq_we = cmd.exec && is_st && !rep;
    assign lpq_waddr = (lpq_cnt_reg == P_FULL) ? lpq_head_reg : p_tail(lpq_head_reg, lpq_cnt_reg);
    assign sq_waddr  = (sq_cnt_reg == P_FULL) ? sq_head_reg : p_tail(sq_head_reg, sq_cnt_reg);

    logic [127:0] hq_rd, sq_rd;
    logic [95:0]  lq_rd, lpq_rd;

    twm_ram #(.WIDTH(128), .DEPTH(TRIGGER_QUEUE_DEPTH)) u_hq (
        .clk(clk), .we(hq_we), .waddr(t_tail(hq_head_reg, hq_cnt_reg)),
        .wdata({t_reg, tb_reg}), .raddr(hq_head_reg), .rdata(hq_rd)
    );
    twm_ram #(.WIDTH(96), .DEPTH(TRIGGER_QUEUE_DEPTH)) u_lq (
        .clk(clk), .we(lq_we), .waddr(t_tail(lq_head_reg, lq_cnt_reg)),
        .wdata({t_reg, tb_reg[31:0]}), .raddr(lq_head_reg), .rdata(lq_rd)
    );
    twm_ram #(.WIDTH(96), .DEPTH(PAYLOAD_QUEUE_DEPTH)) u_lpq (
        .clk(clk), .we(lq_we), .waddr(lpq_waddr),
        .wdata({t_reg, tb_reg[31:0]}), .raddr(lpq_head_reg), .rdata(lpq_rd)
    );
    twm_ram #(.WIDTH(128), .DEPTH(PAYLOAD_QUEUE_DEPTH)) u_sq (
        .clk(clk), .we(sq_we), .waddr(sq_waddr),
        .wdata({st_time, st_pay}), .raddr(sq_head_reg), .rdata(sq_rd)
    );

    // head entries of the side being matched
    logic [63:0] trig_time, trig_word, pay_time, pay_word, ref_prev, limit;

    assign trig_time = cmd.side_hlt ? hq_rd[127:64] : lq_rd[95:32];
    assign trig_word = cmd.side_hlt ? hq_rd[63:0] : {32'b0, lq_rd[31:0]};
    assign pay_time  = cmd.side_hlt ? lpq_rd[95:32] : sq_rd[127:64];
    assign pay_word  = cmd.side_hlt ? {32'b0, lpq_rd[31:0]} : sq_rd[63:0];
    assign ref_prev  = cmd.side_hlt ? prev_hlt_time_reg : prev_llt_time_reg;
    assign limit     = trig_time + 64'(timeout_reg);

    logic can_emit;
    assign can_emit = !pend_valid_reg || !out_valid_reg || out_ready;

    always_comb
    begin
        st             = '0;
        st.exec_emit   = rep || ovf;
        st.exec_repeat = rep;
        st.trig_empty  = cmd.side_hlt ? (hq_cnt_reg == '0) : (lq_cnt_reg == '0);
        st.pay_empty   = cmd.side_hlt ? (lpq_cnt_reg == '0) : (sq_cnt_reg == '0);
        st.timed_out   = ref_prev > limit;
        st.pay_less    = pay_time < want_reg;
        st.pay_equal   = pay_time == want_reg;
        st.can_emit    = can_emit;
        st.pend_valid  = pend_valid_reg;
    end

    // result being produced
    result_t new_res;

    always_comb
    begin
        new_res            = '0;
        new_res.error_seen = err_reg;
        unique case (cmd.sel)
            EM_EXEC:
            begin
                new_res.from_hlt   = is_hlt;
                new_res.frame_time = is_st ? st_time : t_reg;
                priority if (is_hlt)
                begin
                    new_res.frame_payload = {3'b0, tb_reg[60:0]};
                    new_res.frame_trigger = tb_reg[31:0];
                    new_res.kind = (tb_reg[60:0] != prev_hlt_bits_reg)
                                 ? KIND_REPEAT_DIFF : KIND_REPEAT_SAME;
                end
                else if (is_llt)
                begin
                    new_res.frame_payload = {32'b0, tb_reg[31:0]};
                    new_res.frame_trigger = tb_reg[31:0];
                    new_res.kind = (tb_reg[31:0] != prev_llt_bits_reg)
                                 ? KIND_REPEAT_DIFF : KIND_REPEAT_SAME;
                end
                else
                begin
                    new_res.frame_payload = st_pay;
                    new_res.kind = (st_pay != prev_st_bits_reg)
                                 ? KIND_REPEAT_DIFF : KIND_REPEAT_SAME;
                end
                if (ovf)
                begin
                    new_res.kind = KIND_OVERFLOW;
                end
            end
            EM_TIMEOUT:
            begin
                new_res.kind          = KIND_TIMEOUT;
                new_res.from_hlt      = cmd.side_hlt;
                new_res.frame_time    = trig_time;
                new_res.frame_trigger = trig_word[31:0];
            end
            EM_MATCH:
            begin
                new_res.kind          = KIND_FRAME;
                new_res.from_hlt      = cmd.side_hlt;
                new_res.frame_time    = trig_time;
                new_res.frame_payload = pay_word;
                new_res.frame_trigger = trig_word[31:0];
            end
            EM_NOMATCH:
            begin
                // fake hlt reports as a frame with empty payload
                new_res.kind = (cmd.side_hlt && (trig_word == FAKE_HLT_A
                                || trig_word == FAKE_HLT_B)) ? KIND_FRAME : KIND_NO_MATCH;
                new_res.from_hlt      = cmd.side_hlt;
                new_res.frame_time    = trig_time;
                new_res.frame_trigger = trig_word[31:0];
            end
            default:
            begin
                new_res.kind = KIND_NO_MATCH;
            end
        endcase
        new_res.frame_sequence = new_res.from_hlt ? hlt_seq_reg : llt_seq_reg;
    end

    // held result marked as the final one of its item
    result_t last_res;

    always_comb
    begin
        last_res      = pend_reg;
        last_res.last = 1'b1;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            t_reg    <= time_req;
            tb_reg   <= trigger_bits;
            beam_reg <= beam_status;
            crt_reg  <= crt_status;
            pds_reg  <= pds_status;
        end
        if (cmd.load_want)
        begin
            want_reg <= trig_time - 64'd1;
        end
        if (cmd.emit)
        begin
            pend_reg <= new_res;
        end
        if (cmd.emit && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
        else if (cmd.flush)
        begin
            out_reg <= last_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg       <= TIMEOUT_RESET;
            ref_time_reg      <= '0;
            err_reg           <= 1'b0;
            prev_hlt_time_reg <= '0;
            prev_hlt_bits_reg <= '0;
            prev_llt_time_reg <= '0;
            prev_llt_bits_reg <= '0;
            prev_st_time_reg  <= '0;
            prev_st_bits_reg  <= '0;
            hlt_seq_reg       <= '0;
            llt_seq_reg       <= '0;
            hq_head_reg       <= '0;
            hq_cnt_reg        <= '0;
            lq_head_reg       <= '0;
            lq_cnt_reg        <= '0;
            lpq_head_reg      <= '0;
            lpq_cnt_reg       <= '0;
            sq_head_reg       <= '0;
            sq_cnt_reg        <= '0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                if (op_reg == OP_TIME)
                begin
                    ref_time_reg <= t_reg;
                end
                if (op_reg == OP_FEEDBACK)
                begin
                    err_reg <= 1'b1;
                end
            end
            if (hq_we)
            begin
                hq_cnt_reg        <= hq_cnt_reg + TCW'(1);
                hlt_seq_reg       <= hlt_seq_reg + 32'd1;
                prev_hlt_time_reg <= t_reg;
                prev_hlt_bits_reg <= tb_reg[60:0];
            end
            if (lq_we)
            begin
                lq_cnt_reg        <= lq_cnt_reg + TCW'(1);
                llt_seq_reg       <= llt_seq_reg + 32'd1;
                prev_llt_time_reg <= t_reg;
                prev_llt_bits_reg <= tb_reg[31:0];
                if (lpq_cnt_reg == P_FULL)
                begin
                    lpq_head_reg <= p_inc(lpq_head_reg);
                end
                else
                begin
                    lpq_cnt_reg <= lpq_cnt_reg + PCW'(1);
                end
            end
            if (sq_we)
            begin
                prev_st_time_reg <= st_time;
                prev_st_bits_reg <= st_pay;
                if (sq_cnt_reg == P_FULL)
                begin
                    sq_head_reg <= p_inc(sq_head_reg);
                end
                else
                begin
                    sq_cnt_reg <= sq_cnt_reg + PCW'(1);
                end
            end
            if (cmd.pop_trig)
            begin
                if (cmd.side_hlt)
                begin
                    hq_head_reg <= t_inc(hq_head_reg);
                    hq_cnt_reg  <= hq_cnt_reg - TCW'(1);
                end
                else
                begin
                    lq_head_reg <= t_inc(lq_head_reg);
                    lq_cnt_reg  <= lq_cnt_reg - TCW'(1);
                end
            end
            if (cmd.pop_pay)
            begin
                if (cmd.side_hlt)
                begin
                    lpq_head_reg <= p_inc(lpq_head_reg);
                    lpq_cnt_reg  <= lpq_cnt_reg - PCW'(1);
                end
                else
                begin
                    sq_head_reg <= p_inc(sq_head_reg);
                    sq_cnt_reg  <= sq_cnt_reg - PCW'(1);
                end
            end
            // one result is held back so that the final one can carry last
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.emit && pend_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

>>> tb/trigger_word_timestamp_matcher_test.sv
`timescale 1ns / 1ps

module trigger_word_timestamp_matcher_test;
    import twm_pkg::*;

    localparam int TRIG_DEPTH  = 16;
    localparam int PAY_DEPTH   = 32;
    localparam int ITEM_TARGET = 330;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 3000;
    // worst single item skips every queued payload on both sides
    localparam int SETTLE      = 400;

    // one decoded trigger-board word
    typedef struct {
        logic [2:0]  op;
        logic [63:0] time_req;
        logic [63:0] trigger_bits;
        logic [15:0] beam;
        logic [31:0] crt;
        logic [15:0] pds;
    } word_t;

    // queued trigger or payload: timestamp plus its bits
    typedef struct {
        logic [63:0] stamp;
        logic [63:0] bits;
    } slot_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [9:0] cfg_wdata;

    twm_in_if  words_if();
    twm_out_if results_if();

    trigger_word_timestamp_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .words    (words_if),
        .results  (results_if)
    );

    // shadow state of the matcher
    logic [9:0]  timeout_ticks;
    logic [63:0] ref_time;
    logic        err_flag;
    logic [63:0] prev_hlt_time, prev_hlt_bits;
    logic [63:0] prev_llt_time, prev_llt_bits;
    logic [63:0] prev_status_time, prev_status_bits;
    slot_t       hlt_triggers[$];
    slot_t       llt_triggers[$];
    slot_t       llt_payloads[$];
    slot_t       status_payloads[$];
    logic [31:0] hlt_count, llt_count;

    // results still owed by the block, oldest first
    result_t     pending_results[$];
    result_t     step_results[$];

    int          errors;
    int          items_sent;
    int unsigned cycles;
    logic [63:0] seq_time;      // running timestamp base of the sequences

    // handshake pacing controls
    bit          steady;        // no idling on either side
    bit          hold_request;  // asks the result side for one long stall
    int          hold_left;

    // clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic void add_result(logic [2:0] kind, bit hlt, logic [63:0] stamp,
                                       logic [63:0] payload, logic [63:0] trig);
        result_t r;
        r.kind           = kind;
        r.from_hlt       = hlt;
        r.frame_time     = stamp;
        r.frame_payload  = payload;
        r.frame_trigger  = trig[31:0];
        r.frame_sequence = hlt ? hlt_count : llt_count;
        r.error_seen     = err_flag;
        r.last           = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    // resolve queued triggers of one side against their payload queue
    function automatic void resolve(ref slot_t trig[$], ref slot_t pay[$], input bit hlt,
                                    input logic [63:0] newest);
        slot_t       head;
        slot_t       cand;
        logic [63:0] want;
        bit          done;
        while (trig.size() > 0)
        begin
            head = trig[0];
            // stale trigger: newest kept time of this kind is past its window
            if (newest > head.stamp + 64'(timeout_ticks))
            begin
                add_result(KIND_TIMEOUT, hlt, head.stamp, 64'd0, head.bits);
                trig.delete(0);
                continue;
            end
            if (pay.size() == 0)
                break;
            done = 1'b0;
            want = head.stamp - 64'd1;
            while (pay.size() > 0 && !done)
            begin
                cand = pay[0];
                if (cand.stamp < want)
                    pay.delete(0);
                else if (cand.stamp == want)
                begin
                    add_result(KIND_FRAME, hlt, head.stamp, cand.bits, head.bits);
                    trig.delete(0);
                    pay.delete(0);
                    done = 1'b1;
                end
                else
                begin
                    // fake HLTs still yield an empty frame
                    if (hlt && (head.bits == FAKE_HLT_A || head.bits == FAKE_HLT_B))
                        add_result(KIND_FRAME, 1'b1, head.stamp, 64'd0, head.bits);
                    else
                        add_result(KIND_NO_MATCH, hlt, head.stamp, 64'd0, head.bits);
                    trig.delete(0);
                    done = 1'b1;
                end
            end
        end
    endfunction

    function automatic void push_payload(ref slot_t pay[$], input logic [63:0] stamp,
                                         input logic [63:0] bits);
        slot_t s;
        // full payload queue drops its oldest entry
        if (pay.size() >= PAY_DEPTH)
            pay.delete(0);
        s.stamp = stamp;
        s.bits  = bits;
        pay.insert(pay.size(), s);
    endfunction

    function automatic void predict_word(word_t w);
        logic [63:0] bits;
        logic [63:0] stamp;
        slot_t       s;
        bit          repeated;
        repeated = 1'b0;
        step_results.delete();
        case (w.op)
            OP_TIME:
                ref_time = w.time_req;
            OP_FEEDBACK:
                err_flag = 1'b1;
            OP_HLT:
            begin
                bits = w.trigger_bits & 64'h1FFF_FFFF_FFFF_FFFF;
                if (w.time_req == prev_hlt_time)
                begin
                    add_result(bits != prev_hlt_bits ? KIND_REPEAT_DIFF : KIND_REPEAT_SAME,
                               1'b1, w.time_req, bits, w.trigger_bits);
                    repeated = 1'b1;
                end
                else if (hlt_triggers.size() >= TRIG_DEPTH)
                    add_result(KIND_OVERFLOW, 1'b1, w.time_req, bits, w.trigger_bits);
                else
                begin
                    s.stamp = w.time_req;
                    s.bits  = w.trigger_bits;
                    hlt_triggers.insert(hlt_triggers.size(), s);
                    hlt_count++;
                    prev_hlt_time = w.time_req;
                    prev_hlt_bits = bits;
                end
            end
            OP_LLT:
            begin
                bits = {32'd0, w.trigger_bits[31:0]};
                if (w.time_req == prev_llt_time)
                begin
                    add_result(bits != prev_llt_bits ? KIND_REPEAT_DIFF : KIND_REPEAT_SAME,
                               1'b0, w.time_req, bits, w.trigger_bits);
                    repeated = 1'b1;
                end
                else if (llt_triggers.size() >= TRIG_DEPTH)
                    add_result(KIND_OVERFLOW, 1'b0, w.time_req, bits, w.trigger_bits);
                else
                begin
                    s.stamp = w.time_req;
                    s.bits  = bits;
                    llt_triggers.insert(llt_triggers.size(), s);
                    push_payload(llt_payloads, w.time_req, bits);
                    llt_count++;
                    prev_llt_time = w.time_req;
                    prev_llt_bits = bits;
                end
            end
            OP_STATUS:
            begin
                // top nibble of the time comes from the reference time
                stamp = {ref_time[63:60], w.time_req[59:0]};
                bits  = {w.pds, w.crt, w.beam};
                if (stamp == prev_status_time)
                begin
                    add_result(bits != prev_status_bits ? KIND_REPEAT_DIFF : KIND_REPEAT_SAME,
                               1'b0, stamp, bits, 64'd0);
                    repeated = 1'b1;
                end
                else
                begin
                    push_payload(status_payloads, stamp, bits);
                    prev_status_time = stamp;
                    prev_status_bits = bits;
                end
            end
            default:
                ;
        endcase
        if (!repeated)
        begin
            resolve(hlt_triggers, llt_payloads, 1'b1, prev_hlt_time);
            resolve(llt_triggers, status_payloads, 1'b0, prev_llt_time);
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            pending_results.insert(pending_results.size(), step_results[i]);
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none actual kind %0d time %h",
                         $time, results_if.kind, results_if.frame_time);
                errors++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("kind", want.kind, results_if.kind);
                check_field("from_hlt", want.from_hlt, results_if.from_hlt);
                check_field("frame_time", want.frame_time, results_if.frame_time);
                check_field("frame_payload", want.frame_payload, results_if.frame_payload);
                check_field("frame_trigger", want.frame_trigger, results_if.frame_trigger);
                check_field("frame_sequence", want.frame_sequence,
                            results_if.frame_sequence);
                check_field("error_seen", want.error_seen, results_if.error_seen);
                check_field("last", want.last, results_if.last);
            end
        end
    end

    // result side ready: random stalls, a long hold on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            results_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left <= LONG_HOLD;
            results_if.ready <= 1'b0;
        end
        else if (steady)
            results_if.ready <= 1'b1;
        else if ($urandom_range(0, 40) == 0)
        begin
            hold_left <= $urandom_range(15, 70);
            results_if.ready <= 1'b0;
        end
        else
            results_if.ready <= ($urandom_range(0, 3) != 0);
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic word_t make_word(logic [2:0] op, logic [63:0] stamp,
                                        logic [63:0] trig);
        word_t w;
        w.op           = op;
        w.time_req     = stamp;
        w.trigger_bits = trig;
        w.beam         = 16'($urandom);
        w.crt          = $urandom;
        w.pds          = 16'($urandom);
        return w;
    endfunction

    // most gaps short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_word(word_t w);
        int gap;
        @(negedge clk);
        words_if.op           <= w.op;
        words_if.time_req     <= w.time_req;
        words_if.trigger_bits <= w.trigger_bits;
        words_if.beam_status  <= w.beam;
        words_if.crt_status   <= w.crt;
        words_if.pds_status   <= w.pds;
        words_if.valid        <= 1'b1;
        @(posedge clk);
        while (!words_if.ready)
            @(posedge clk);
        predict_word(w);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            words_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering, wait for all owed results, then let trailing matching work finish
    task automatic wait_drained();
        @(negedge clk);
        words_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_timeout(logic [9:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        timeout_ticks = value;
    endtask

    // one status/LLT/HLT chain spaced one tick apart, with random faults
    task automatic send_chain();
        int    r;
        word_t w;
        logic [63:0] trig;
        r = $urandom_range(0, 99);
        if (r < 5)
            seq_time = rand64();
        else if (r < 15)
            seq_time += $urandom_range(150, 1500);
        else
            seq_time += $urandom_range(3, 12);
        // noise: any op, any time
        if ($urandom_range(0, 6) == 0)
        begin
            w = make_word(3'($urandom_range(0, 5)),
                          $urandom_range(0, 1) ? rand64() : seq_time + $urandom_range(0, 3),
                          rand64());
            send_word(w);
            return;
        end
        if (r < 15 || $urandom_range(0, 3) == 0)
            send_word(make_word(OP_TIME, seq_time, rand64()));
        if ($urandom_range(0, 9) != 0)
        begin
            // upper nibble of the status time is ignored by the block
            w = make_word(OP_STATUS, {4'($urandom), seq_time[59:0]}, rand64());
            send_word(w);
            if ($urandom_range(0, 12) == 0)
            begin
                if ($urandom_range(0, 1))
                    w.beam = ~w.beam;
                send_word(w);
            end
        end
        if ($urandom_range(0, 7) != 0)
        begin
            w = make_word(OP_LLT, seq_time + 64'd1, rand64());
            send_word(w);
            if ($urandom_range(0, 12) == 0)
                send_word(make_word(OP_LLT, seq_time + 64'd1, rand64()));
        end
        if ($urandom_range(0, 7) != 0)
        begin
            case ($urandom_range(0, 9))
                0: trig = FAKE_HLT_A;
                1: trig = FAKE_HLT_B;
                default: trig = rand64();
            endcase
            w = make_word(OP_HLT, seq_time + ($urandom_range(0, 9) == 0 ? 64'd5 : 64'd2),
                          trig);
            send_word(w);
            if ($urandom_range(0, 12) == 0)
                send_word(w);
        end
    endtask

    task automatic send_chains(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            send_chain();
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // repeats against the reset state, extremes, overflow
    task automatic test_directed();
        word_t w;
        send_word(make_word(OP_HLT, 64'd0, 64'd0));            // repeat, same bits
        send_word(make_word(OP_HLT, 64'd0, '1));               // repeat, other bits
        send_word(make_word(OP_LLT, 64'd0, 64'd0));
        w = make_word(OP_STATUS, 64'd0, 64'd0);
        w.beam = '0;
        w.crt  = '0;
        w.pds  = '0;
        send_word(w);                                          // status repeat at zero
        send_word(make_word(OP_FEEDBACK, rand64(), rand64()));
        send_word(make_word(OP_TIME, '1, '1));
        w.beam = '1;
        w.crt  = '1;
        w.pds  = '1;
        w.time_req = '1;
        send_word(w);                                          // status with top nibble
        send_word(make_word(OP_OTHER, rand64(), rand64()));    // ignored kind
        // HLTs with nothing to match pile up until the queue overflows
        for (int i = 1; i <= TRIG_DEPTH + 1; i++)
            send_word(make_word(OP_HLT, 64'(i), '1));
    endtask

    task automatic test_timeout_sweep();
        write_timeout(10'd0);
        send_chains(60);
        write_timeout(10'd1023);
        send_chains(60);
        write_timeout(10'($urandom_range(1, 1022)));
        send_chains(50);
        write_timeout(TIMEOUT_RESET);
    endtask

    // results held off long enough that the block stalls its input
    task automatic test_backpressure();
        steady = 1'b1;
        hold_request = 1'b1;
        send_chains(50);
        steady = 1'b0;
    endtask

    // sender waits for every owed result, then resumes
    task automatic test_pause_resume();
        send_chains(30);
        wait_drained();
        send_chains(40);
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        cycles = 0;
        steady = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        words_if.valid = 1'b0;
        words_if.op = OP_TIME;
        words_if.time_req = '0;
        words_if.trigger_bits = '0;
        words_if.beam_status = '0;
        words_if.crt_status = '0;
        words_if.pds_status = '0;
        results_if.ready = 1'b0;

        timeout_ticks = TIMEOUT_RESET;
        ref_time = '0;
        err_flag = 1'b0;
        prev_hlt_time = '0;
        prev_hlt_bits = '0;
        prev_llt_time = '0;
        prev_llt_bits = '0;
        prev_status_time = '0;
        prev_status_bits = '0;
        hlt_count = '0;
        llt_count = '0;
        seq_time = 64'd1000;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_timeout_sweep();
        test_backpressure();
        test_pause_resume();

        @(negedge clk);
        words_if.valid <= 1'b0;
        wait_drained();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
